FILE: rtl/core/spss_pkg.sv
// ---------------------------------------------------------------------------
// spss_pkg
// shared constants for the splice-search sample player
// ---------------------------------------------------------------------------
package spss_pkg;

  localparam int STORE_DEPTH_DEFAULT   = 4096;
  localparam int SAMPLE_BITS_DEFAULT   = 16;
  localparam int FRACTION_BITS_DEFAULT = 16;
  localparam int GAIN_SHIFT            = 12;
  localparam int GAIN_BITS             = 16;
  localparam int INCR_BITS             = 29;
  localparam int FRAME_BITS            = 12;
  localparam int PHASE_BITS            = 32;

  localparam logic [2:0] REG_AMPLITUDE    = 3'd0;
  localparam logic [2:0] REG_INCREMENT    = 3'd1;
  localparam logic [2:0] REG_SEARCH_START = 3'd2;
  localparam logic [2:0] REG_SEARCH_END   = 3'd3;
  localparam logic [2:0] REG_LAST_FRAME   = 3'd4;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic KIND_AUDIO = 1'b0;
  localparam logic KIND_START = 1'b1;

endpackage

FILE: rtl/core/spss_ram.sv
// ---------------------------------------------------------------------------
// spss_ram
// single-port ram with registered read
// ---------------------------------------------------------------------------
module spss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: rtl/core/sample_player_splice_search.sv
// ---------------------------------------------------------------------------
// sample_player_splice_search
// one-channel sample player: linear interpolation, gain, splice-point search
// ---------------------------------------------------------------------------
//
// channel   direction  content
// s_axis    in         tdata {load_value, load_address}, tuser cmd
// m_axis    out        tdata {chosen_start, audio_out}, tuser kind
// cfg       in         cfg_we / cfg_index / cfg_data, plain writes
//
// a load writes the sample ram; a tick makes two reads of the single sample-ram port,
// uses one multiplier for interpolation and gain in turn, then saturates and hands off
// a start with search scores each candidate at two points, sharing the value unit
// rst is synchronous; the ram contents are not cleared
// the output register holds a result until m_axis_tready; s_axis_tready
// stays low from request to the result being taken
// ---------------------------------------------------------------------------
module sample_player_splice_search #(
  parameter int STORE_DEPTH   = spss_pkg::STORE_DEPTH_DEFAULT,
  parameter int FRACTION_BITS = spss_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // load_address[11:0], load_value[27:12], zero pad
  input  logic [31:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // audio_out[15:0], chosen_start[47:16]
  output logic [47:0] m_axis_tdata,
  // kind[0]
  output logic        m_axis_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [28:0] cfg_data
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FB = spss_pkg::FRAME_BITS;
  localparam int PB = spss_pkg::PHASE_BITS;
  localparam int SB = spss_pkg::SAMPLE_BITS_DEFAULT;
  localparam int WB = SB + 24;  // working width for values and fits
  localparam int HI = (1 << (SB - 1)) - 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_VSTART, ST_RD1, ST_RD2, ST_INTERP, ST_GAIN, ST_SAT,
    ST_FIT, ST_OUT
  } state_t;

  state_t state;
  logic   searching, second_pt;
  logic [15:0] amplitude;
  logic [28:0] increment;
  logic [FB-1:0] search_start, search_end, last_frame;
  logic [PB-1:0] phase, cand, best_phase, vpos;
  logic [WB-1:0] best_fit;
  logic signed [SB-1:0] h_r, h_m, h_o, a_val;
  logic signed [SB-1:0] s1, s2;
  logic signed [WB-1:0] acc;
  logic signed [WB-1:0] p1, p2;
  logic [47:0] out_data;
  logic out_kind, out_valid;

  // ram port
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [SB-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0] load_addr_r;
  logic [SB-1:0] load_val_r;

  spss_ram #(.WIDTH(SB), .DEPTH(STORE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // value-unit position split
  logic [PB-FRACTION_BITS-1:0] vframe;
  logic [FRACTION_BITS-1:0] vfrac;
  assign vframe = vpos[PB-1:FRACTION_BITS];
  assign vfrac  = vpos[FRACTION_BITS-1:0];
  logic beyond, wrap_next;
  assign beyond    = PB'(vframe) > PB'(last_frame);
  assign wrap_next = PB'(vframe) >= PB'(last_frame);

  always_comb begin
    ram_we    = (state == ST_LOAD);
    ram_wdata = load_val_r;
    ram_addr  = load_addr_r;
    if (state == ST_VSTART) ram_addr = AW'(vframe);
    else if (state == ST_RD1) ram_addr = wrap_next ? '0 : AW'(vframe + 1'b1);
  end

  // shared multiplier, one product per cycle
  logic signed [WB-1:0] mul_a;
  logic signed [FRACTION_BITS+1:0] mul_b;
  logic signed [WB+FRACTION_BITS+1:0] product;
  always_comb begin
    if (state == ST_INTERP) begin
      mul_a = WB'(s2) - WB'(s1);
      mul_b = $signed({2'b00, vfrac});
    end else begin
      mul_a = acc;
      mul_b = (FRACTION_BITS+2)'($signed({1'b0, amplitude}));
    end
    product = mul_a * mul_b;
  end

  logic signed [WB-1:0] sat_v;
  always_comb begin
    if (acc > WB'(HI)) sat_v = WB'(HI);
    else if (acc < -WB'(HI) - 1) sat_v = -WB'(HI) - 1;
    else sat_v = acc;
  end

  // fit of a candidate: 2|2a - p1| + |b - p2|
  logic signed [WB-1:0] d1, d2;
  logic [WB-1:0] fit;
  always_comb begin
    d1  = 2 * WB'(a_val) - p1;
    d2  = sat_v - p2;
    fit = 2 * (d1 < 0 ? -d1 : d1) + (d2 < 0 ? -d2 : d2);
  end

  logic [PB:0] tick_next, cand_next;
  assign tick_next = {1'b0, phase} + (PB+1)'(increment);
  assign cand_next = {1'b0, cand} + (PB+1)'(increment);

  logic [PB-1:0] end_phase;
  assign end_phase = PB'(search_end) << FRACTION_BITS;

  assign s_axis_tready = (state == ST_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      phase        <= '0;
      h_r          <= '0;
      h_m          <= '0;
      h_o          <= '0;
      amplitude    <= 16'd4096;
      increment    <= 29'd65536;
      search_start <= '0;
      search_end   <= '0;
      last_frame   <= 12'd4095;
      searching    <= 1'b0;
      second_pt    <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          spss_pkg::REG_AMPLITUDE:    amplitude    <= cfg_data[15:0];
          spss_pkg::REG_INCREMENT:    increment    <= cfg_data;
          spss_pkg::REG_SEARCH_START: search_start <= cfg_data[FB-1:0];
          spss_pkg::REG_SEARCH_END:   search_end   <= cfg_data[FB-1:0];
          spss_pkg::REG_LAST_FRAME:   last_frame   <= cfg_data[FB-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            load_addr_r <= AW'(s_axis_tdata[11:0]);
            load_val_r  <= SB'($signed(s_axis_tdata[27:12]));
            case (s_axis_tuser)
              spss_pkg::CMD_LOAD: state <= ST_LOAD;
              spss_pkg::CMD_START: begin
                cand       <= PB'(search_start) << FRACTION_BITS;
                best_phase <= PB'(search_start) << FRACTION_BITS;
                best_fit   <= '1;
                p1 <= 5 * WB'(h_r) - 4 * WB'(h_m) + WB'(h_o);
                p2 <= 5 * WB'(h_r) - 6 * WB'(h_m) + 2 * WB'(h_o);
                vpos       <= PB'(search_start) << FRACTION_BITS;
                second_pt  <= 1'b0;
                if (search_start < search_end) begin
                  searching <= 1'b1;
                  state     <= ST_VSTART;
                end else begin
                  phase     <= PB'(search_start) << FRACTION_BITS;
                  out_data  <= {PB'(search_start) << FRACTION_BITS, 16'd0};
                  out_kind  <= spss_pkg::KIND_START;
                  out_valid <= 1'b1;
                end
              end
              spss_pkg::CMD_TICK: begin
                searching <= 1'b0;
                vpos      <= phase;
                state     <= ST_VSTART;
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: state <= ST_IDLE;
        ST_VSTART: state <= ST_RD1;
        ST_RD1: begin
          s1    <= ram_rdata;
          state <= ST_RD2;
        end
        ST_RD2: begin
          s2    <= ram_rdata;
          state <= ST_INTERP;
        end
        ST_INTERP: begin
          if (beyond) acc <= '0;
          else if (vfrac == '0) acc <= WB'(s1);
          else acc <= WB'(s1) + WB'(product >>> FRACTION_BITS);
          state <= ST_GAIN;
        end
        ST_GAIN: begin
          acc   <= WB'(product >>> spss_pkg::GAIN_SHIFT);
          state <= ST_SAT;
        end
        ST_SAT: begin
          if (!searching) begin
            h_o       <= h_m;
            h_m       <= h_r;
            h_r       <= SB'(sat_v);
            phase     <= tick_next[PB] ? '1 : tick_next[PB-1:0];
            out_data  <= {32'd0, 16'(SB'(sat_v))};
            out_kind  <= spss_pkg::KIND_AUDIO;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else if (!second_pt) begin
            a_val     <= SB'(sat_v);
            second_pt <= 1'b1;
            vpos      <= cand_next[PB-1:0];
            state     <= ST_VSTART;
          end else begin
            state <= ST_FIT;
          end
        end
        ST_FIT: begin
          second_pt <= 1'b0;
          if (fit < best_fit) begin
            best_fit   <= fit;
            best_phase <= cand;
          end
          if (increment != '0 && !cand_next[PB] && cand_next[PB-1:0] < end_phase) begin
            cand  <= cand_next[PB-1:0];
            vpos  <= cand_next[PB-1:0];
            state <= ST_VSTART;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          phase     <= best_phase;
          out_data  <= {best_phase, 16'd0};
          out_kind  <= spss_pkg::KIND_START;
          out_valid <= 1'b1;
          searching <= 1'b0;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // no request taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !s_axis_tready) else $error("ready while result pending");
  // held result stays put under stall
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> $stable(out_data))
    else $error("result changed under stall");
  // audio results carry no start phase
  a_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == spss_pkg::KIND_AUDIO) |-> out_data[47:16] == '0)
    else $error("audio result with phase");
endmodule
